@@ rtl/ctts_pkg.sv @@
package ctts_pkg;

  localparam int SLOT_COUNT_DEF = 16;
  localparam int RESULT_LIMIT   = 16;
  localparam int CNT_W          = $clog2(RESULT_LIMIT + 1);

  typedef enum logic [1:0] {
    MODE_ADD      = 2'd0,
    MODE_DELETE   = 2'd1,
    MODE_TICK     = 2'd2,
    MODE_DISPATCH = 2'd3
  } mode_t;

  typedef struct packed {
    logic [7:0]  handle;
    logic [15:0] delay;
    logic [15:0] period;
    logic [7:0]  pend;
  } slot_entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic add_wr;      // write an add transaction straight from the input fields
    logic load;        // latch the handle of a delete transaction
    logic rd;          // read the slot memory at addr
    logic wr_tick;     // write back the ticked entry
    logic wr_clear;    // write back the entry with its handle cleared
    logic disp_take;   // consume one run, push the held result, hold this one
    logic push_final;  // push the held result as the last of the pass
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic due;
    logic del_hit;
    logic os_hit;
    logic one_shot;
    logic out_free;
    logic held_valid;
  } sts_t;

endpackage

@@ rtl/cooperative_tick_task_scheduler.sv @@
// Tick-driven cooperative task scheduler over SLOT_COUNT priority slots held in a
// single-port slot memory; each slot visit is a read state, then an evaluate/write state.
// An add transaction is written straight from the input fields. A delete visits the
// slots in turn up to the first match; a tick visits every slot. A dispatch visits the
// slots in turn until the last slot or RESULT_LIMIT results; for each one-shot task
// dispatched from slot k it searches slots 0 up to k to remove it, releases the last
// result when there is one, and waits while the output is stalled. Each dispatched
// task gives one result transaction on the output; last marks the final one of the
// pass. The input is stalled until the current transaction has finished its sweep.
module cooperative_tick_task_scheduler
  import ctts_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [3:0]  slot,
  input  logic [7:0]  task_handle,
  input  logic [15:0] start_delay,
  input  logic [15:0] repeat_period,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  run_slot,
  output logic [7:0]  run_handle,
  output logic        last
);

  localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  cmd_t          cmd;
  sts_t          sts;
  logic [AW-1:0] addr;

  ctts_ctrl #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .mode    (mode),
    .sts     (sts),
    .cmd     (cmd),
    .addr    (addr)
  );

  ctts_dp #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .addr         (addr),
    .slot         (slot),
    .task_handle  (task_handle),
    .start_delay  (start_delay),
    .repeat_period(repeat_period),
    .sts          (sts),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .run_slot     (run_slot),
    .run_handle   (run_handle),
    .last         (last)
  );

`ifndef NO_ASSERTIONS
  a_idle_nothing_held: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !sts.held_valid)
    else $error("input accepted while a dispatch result is still held");

  a_no_output_overrun: assert property (@(posedge clk) disable iff (rst)
    (cmd.disp_take && sts.held_valid) |-> sts.out_free)
    else $error("held result pushed over an untaken output transaction");

  a_final_push_ok: assert property (@(posedge clk) disable iff (rst)
    cmd.push_final |-> (sts.held_valid && sts.out_free))
    else $error("final push without a held result or free output");

  a_take_only_due: assert property (@(posedge clk) disable iff (rst)
    cmd.disp_take |-> sts.due)
    else $error("run consumed from a slot with no pending run");
`endif

endmodule

@@ rtl/ctts_dp.sv @@
module ctts_dp
  import ctts_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF,
  localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  cmd_t          cmd,
  input  logic [AW-1:0] addr,
  input  logic [3:0]    slot,
  input  logic [7:0]    task_handle,
  input  logic [15:0]   start_delay,
  input  logic [15:0]   repeat_period,
  output sts_t          sts,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [3:0]    run_slot,
  output logic [7:0]    run_handle,
  output logic          last
);

  slot_entry_t             mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0]   vld;
  slot_entry_t             rd_q;
  logic                    rd_vld;
  logic [AW-1:0]           rd_addr;
  slot_entry_t             cur;
  logic [7:0]              cmd_handle;
  logic                    held_valid;
  logic [3:0]              held_slot;
  logic [7:0]              held_handle;
  logic                    add_ok;
  logic                    wr_en;
  logic [AW-1:0]           wr_addr;
  slot_entry_t             wr_data;
  logic                    out_free;
  logic                    push;

  // A slot never written reads as the empty reset entry.
  assign cur = rd_vld ? rd_q : '0;

  assign add_ok   = cmd.add_wr && (task_handle != 8'd0) && (int'(slot) < SLOT_COUNT);
  assign out_free = !out_valid || !out_stall;
  assign push     = (cmd.disp_take && held_valid) || cmd.push_final;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rd_addr;
    wr_data = cur;
    priority if (add_ok) begin
      wr_en          = 1'b1;
      wr_addr        = AW'(slot);
      wr_data.handle = task_handle;
      wr_data.delay  = start_delay;
      wr_data.period = repeat_period;
      wr_data.pend   = 8'd0;
    end else if (cmd.wr_tick && (cur.handle != 8'd0)) begin
      wr_en = 1'b1;
      if (cur.delay != 16'd0) begin
        wr_data.delay = cur.delay - 16'd1;
      end else begin
        if (cur.pend != 8'hFF) begin
          wr_data.pend = cur.pend + 8'd1;
        end
        if (cur.period != 16'd0) begin
          wr_data.delay = cur.period - 16'd1;
        end
      end
    end else if (cmd.wr_clear) begin
      wr_en          = 1'b1;
      wr_data.handle = 8'd0;
    end else if (cmd.disp_take) begin
      wr_en        = 1'b1;
      wr_data.pend = cur.pend - 8'd1;
    end else begin
      wr_en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_q    <= mem[addr];
      rd_addr <= addr;
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (cmd.rd) begin
        rd_vld <= vld[addr];
      end
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_handle <= task_handle;
    end
    if (cmd.disp_take) begin
      held_slot   <= 4'(rd_addr);
      held_handle <= cur.handle;
    end
    if (push) begin
      run_slot   <= held_slot;
      run_handle <= held_handle;
      last       <= cmd.push_final;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.disp_take) begin
        held_valid <= 1'b1;
      end else if (cmd.push_final) begin
        held_valid <= 1'b0;
      end
      if (push) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign sts.due        = (cur.handle != 8'd0) && (cur.pend != 8'd0);
  assign sts.del_hit    = (cur.handle != 8'd0) && (cur.handle == cmd_handle);
  assign sts.os_hit     = (cur.handle == held_handle);
  assign sts.one_shot   = (cur.period == 16'd0);
  assign sts.out_free   = out_free;
  assign sts.held_valid = held_valid;

endmodule

@@ rtl/ctts_ctrl.sv @@
module ctts_ctrl
  import ctts_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF,
  localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [1:0]    mode,
  input  sts_t          sts,
  output cmd_t          cmd,
  output logic [AW-1:0] addr
);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_READ    = 6'b000010,
    S_EVAL    = 6'b000100,
    S_OS_READ = 6'b001000,
    S_OS_EVAL = 6'b010000,
    S_FLUSH   = 6'b100000
  } state_t;

  state_t           state, state_next;
  mode_t            op, op_next;
  logic [AW-1:0]    k, k_next;
  logic [AW-1:0]    j, j_next;
  logic [CNT_W-1:0] n, n_next;
  logic             k_last;
  logic             n_full;

  assign in_stall = (state != S_IDLE);
  assign k_last   = (k == AW'(SLOT_COUNT - 1));
  assign n_full   = (n == CNT_W'(RESULT_LIMIT));

  always_comb begin
    state_next = state;
    op_next    = op;
    k_next     = k;
    j_next     = j;
    n_next     = n;
    cmd        = '0;
    addr       = k;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          unique case (mode_t'(mode))
            MODE_ADD: begin
              cmd.add_wr = 1'b1;
            end
            default: begin
              cmd.load   = 1'b1;
              op_next    = mode_t'(mode);
              k_next     = '0;
              n_next     = '0;
              state_next = S_READ;
            end
          endcase
        end
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = S_EVAL;
      end
      S_EVAL: begin
        unique case (op)
          MODE_TICK: begin
            cmd.wr_tick = 1'b1;
            if (k_last) begin
              state_next = S_IDLE;
            end else begin
              k_next     = k + AW'(1);
              state_next = S_READ;
            end
          end
          MODE_DELETE: begin
            if (sts.del_hit) begin
              cmd.wr_clear = 1'b1;
              state_next   = S_IDLE;
            end else if (k_last) begin
              state_next = S_IDLE;
            end else begin
              k_next     = k + AW'(1);
              state_next = S_READ;
            end
          end
          MODE_DISPATCH: begin
            if (sts.due) begin
              // The previous result leaves only once the output register is free.
              if (!sts.held_valid || sts.out_free) begin
                cmd.disp_take = 1'b1;
                n_next        = n + CNT_W'(1);
                if (sts.one_shot) begin
                  j_next     = '0;
                  state_next = S_OS_READ;
                end else if (k_last || (n_next == CNT_W'(RESULT_LIMIT))) begin
                  state_next = S_FLUSH;
                end else begin
                  k_next     = k + AW'(1);
                  state_next = S_READ;
                end
              end
            end else if (k_last) begin
              state_next = sts.held_valid ? S_FLUSH : S_IDLE;
            end else begin
              k_next     = k + AW'(1);
              state_next = S_READ;
            end
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_OS_READ: begin
        addr       = j;
        cmd.rd     = 1'b1;
        state_next = S_OS_EVAL;
      end
      S_OS_EVAL: begin
        // The dispatched slot itself holds the handle, so the search ends by slot k.
        if (sts.os_hit || (j == k)) begin
          cmd.wr_clear = sts.os_hit;
          if (k_last || n_full) begin
            state_next = S_FLUSH;
          end else begin
            k_next     = k + AW'(1);
            state_next = S_READ;
          end
        end else begin
          j_next     = j + AW'(1);
          state_next = S_OS_READ;
        end
      end
      S_FLUSH: begin
        if (sts.out_free) begin
          cmd.push_final = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= MODE_ADD;
      k     <= '0;
      j     <= '0;
      n     <= '0;
    end else begin
      state <= state_next;
      op    <= op_next;
      k     <= k_next;
      j     <= j_next;
      n     <= n_next;
    end
  end

endmodule

@@ dv/tb_cooperative_tick_task_scheduler.sv @@
`timescale 1ns / 1ps

module tb_cooperative_tick_task_scheduler;
  import ctts_pkg::*;

  localparam int NSLOT = SLOT_COUNT_DEF;
  localparam int RANDOM_ITEMS = 64;
  localparam int DRAIN_CYCLES = 100;

  typedef struct {
    logic [3:0] slot;
    logic [7:0] handle;
    logic       last;
  } run_rec_t;

  class run_scoreboard;
    logic [7:0]  tab_handle [NSLOT];
    logic [15:0] tab_delay  [NSLOT];
    logic [15:0] tab_period [NSLOT];
    logic [7:0]  tab_pend   [NSLOT];
    run_rec_t    due_runs[$];
    int          errors;

    function new();
      int k;
      for (k = 0; k < NSLOT; k++) begin
        tab_handle[k] = '0;
        tab_delay[k]  = '0;
        tab_period[k] = '0;
        tab_pend[k]   = '0;
      end
      errors = 0;
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    // Clears the lowest slot that holds handle h; handle zero matches nothing.
    function void clear_first(logic [7:0] h);
      int k;
      if (h == 8'd0) return;
      for (k = 0; k < NSLOT; k++) begin
        if (tab_handle[k] == h) begin
          tab_handle[k] = 8'd0;
          return;
        end
      end
    endfunction

    function void accept_command(mode_t m, logic [3:0] s, logic [7:0] h,
                                 logic [15:0] d, logic [15:0] p);
      int k;
      int n;
      n = 0;
      case (m)
        MODE_ADD: begin
          if (h != 8'd0 && int'(s) < NSLOT) begin
            tab_handle[s] = h;
            tab_delay[s]  = d;
            tab_period[s] = p;
            tab_pend[s]   = 8'd0;
          end
        end
        MODE_DELETE: clear_first(h);
        MODE_TICK: begin
          for (k = 0; k < NSLOT; k++) begin
            if (tab_handle[k] != 8'd0) begin
              if (tab_delay[k] != 16'd0) begin
                tab_delay[k] = tab_delay[k] - 16'd1;
              end else begin
                if (tab_pend[k] != 8'd255) tab_pend[k] = tab_pend[k] + 8'd1;
                if (tab_period[k] != 16'd0) tab_delay[k] = tab_period[k] - 16'd1;
              end
            end
          end
        end
        default: begin
          for (k = 0; k < NSLOT && n < RESULT_LIMIT; k++) begin
            if (tab_handle[k] != 8'd0 && tab_pend[k] != 8'd0) begin
              due_runs.push_back('{slot: 4'(k), handle: tab_handle[k], last: 1'b0});
              n++;
              tab_pend[k] = tab_pend[k] - 8'd1;
              // A one-shot removal goes by handle, so it may hit a lower duplicate.
              if (tab_period[k] == 16'd0) clear_first(tab_handle[k]);
            end
          end
          if (n > 0) due_runs[due_runs.size() - 1].last = 1'b1;
        end
      endcase
    endfunction

    task check_run(logic [3:0] s, logic [7:0] h, logic l);
      run_rec_t want;
      if (due_runs.size() == 0) begin
        report_mismatch($sformatf("unexpected run slot=%0d handle=%0d last=%0b", s, h, l));
      end else begin
        want = due_runs.pop_front();
        if (s !== want.slot)
          report_mismatch($sformatf("run_slot %0d, expected %0d", s, want.slot));
        if (h !== want.handle)
          report_mismatch($sformatf("run_handle %0d, expected %0d (slot %0d)",
                                    h, want.handle, want.slot));
        if (l !== want.last)
          report_mismatch($sformatf("last %0b, expected %0b (slot %0d)",
                                    l, want.last, want.slot));
      end
    endtask

    function int pending();
      return due_runs.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  mode_t       mode = MODE_ADD;
  logic [3:0]  slot = '0;
  logic [7:0]  task_handle = '0;
  logic [15:0] start_delay = '0;
  logic [15:0] repeat_period = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  run_slot;
  logic [7:0]  run_handle;
  logic        last;

  bit            calm = 1'b0;
  run_scoreboard sb;

  cooperative_tick_task_scheduler DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .slot         (slot),
    .task_handle  (task_handle),
    .start_delay  (start_delay),
    .repeat_period(repeat_period),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .run_slot     (run_slot),
    .run_handle   (run_handle),
    .last         (last)
  );

  always #10 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= !rst && !calm && ($urandom_range(0, 99) < 19);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_run(run_slot, run_handle, last);
  end

  initial begin
    #50_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  task send_item(mode_t m, logic [3:0] s, logic [7:0] h, logic [15:0] d, logic [15:0] p);
    int gap;
    gap = 0;
    if (!calm) begin
      while ($urandom_range(0, 99) < 19) gap++;
    end
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    mode          <= m;
    slot          <= s;
    task_handle   <= h;
    start_delay   <= d;
    repeat_period <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.accept_command(m, s, h, d, p);
  endtask

  // Mostly a small pool so that deletes hit and duplicate handles show up.
  function automatic logic [7:0] pick_handle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 8'd0;
    if (r < 80) return 8'($urandom_range(1, 10));
    return 8'($urandom);
  endfunction

  // Short delays and periods keep tasks coming due; the rest span the full range.
  function automatic logic [15:0] pick_ticks();
    if ($urandom_range(0, 9) < 8) return 16'($urandom_range(0, 4));
    return 16'($urandom);
  endfunction

  initial begin
    int i;
    int r;
    sb = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // One-shot task due at once keeps gaining runs until dispatched.
    send_item(MODE_ADD, 4'd0, 8'd255, 16'd0, 16'd0);
    send_item(MODE_ADD, 4'd15, 8'd1, 16'hFFFF, 16'hFFFF);
    send_item(MODE_ADD, 4'd1, 8'd0, 16'd5, 16'd5);
    send_item(MODE_DELETE, 4'hF, 8'd0, 16'hFFFF, 16'hFFFF);
    send_item(MODE_TICK, 4'hF, 8'hFF, 16'hFFFF, 16'hFFFF);
    send_item(MODE_TICK, 4'd0, 8'd0, 16'd0, 16'd0);
    send_item(MODE_DISPATCH, 4'hA, 8'h55, 16'h5555, 16'hAAAA);
    send_item(MODE_DISPATCH, 4'd5, 8'hAA, 16'hAAAA, 16'h5555);

    // Duplicate handle: the one-shot in slot 5 removes the periodic copy in slot 2.
    send_item(MODE_ADD, 4'd2, 8'd7, 16'd0, 16'd3);
    send_item(MODE_ADD, 4'd5, 8'd7, 16'd1, 16'd0);
    send_item(MODE_TICK, 4'd0, 8'd0, 16'd0, 16'd0);
    send_item(MODE_TICK, 4'd0, 8'd0, 16'd0, 16'd0);
    send_item(MODE_DISPATCH, 4'd0, 8'd0, 16'd0, 16'd0);
    send_item(MODE_DELETE, 4'd0, 8'd7, 16'd0, 16'd0);
    send_item(MODE_DELETE, 4'd0, 8'd99, 16'd0, 16'd0);

    // Every slot due in the same pass.
    for (i = 0; i < NSLOT; i++) begin
      send_item(MODE_ADD, 4'(i), 8'(i + 16), 16'd0, (i % 2 == 1) ? 16'hFFFF : 16'd1);
    end
    send_item(MODE_TICK, 4'd0, 8'd0, 16'd0, 16'd0);
    send_item(MODE_DISPATCH, 4'd0, 8'd0, 16'd0, 16'd0);

    // Run counts pile up past the saturation point.
    send_item(MODE_ADD, 4'd3, 8'd200, 16'd0, 16'd0);
    for (i = 0; i < 260; i++) begin
      send_item(MODE_TICK, 4'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
    end
    send_item(MODE_DISPATCH, 4'd0, 8'd0, 16'd0, 16'd0);
    send_item(MODE_DISPATCH, 4'd0, 8'd0, 16'd0, 16'd0);

    for (i = 0; i < RANDOM_ITEMS; i++) begin
      calm = (i >= 16 && i < 44);
      r = $urandom_range(0, 99);
      if (r < 28) begin
        send_item(MODE_ADD, 4'($urandom), pick_handle(), pick_ticks(), pick_ticks());
      end else if (r < 38) begin
        send_item(MODE_DELETE, 4'($urandom), pick_handle(), 16'($urandom), 16'($urandom));
      end else if (r < 75) begin
        send_item(MODE_TICK, 4'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
      end else begin
        send_item(MODE_DISPATCH, 4'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
      end
    end
    calm = 1'b0;

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0) sb.report_mismatch("expected runs never arrived");

    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
